### rtl/assert_macros.svh
// Assertion macros used by the checker file of the S-record loader.
// Depends on nothing; take in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SREC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SREC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/srec_pkg.sv
// Shared types, character codes and the character classifier of the S-record loader.
// Depends on nothing.
package srec_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_3 = 8'h33;
   localparam logic [7:0] CHAR_7 = 8'h37;

   localparam logic [3:0] S0_ADDR_DIGITS = 4'd4;
   localparam logic [3:0] S3_ADDR_DIGITS = 4'd8;
   localparam logic [7:0] S0_OVERHEAD    = 8'd3;
   localparam logic [7:0] S3_OVERHEAD    = 8'd5;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_DONE,
      KIND_TYPE,
      KIND_HEX
   } kind_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_COUNT,
      PH_S0ADR,
      PH_S0DAT,
      PH_S3ADR,
      PH_S3DAT
   } phase_type;

   // One classified character as it travels from front to back.
   typedef struct packed {
      logic       is_s;
      logic       hex_ok;
      logic [3:0] nib;
      logic [7:0] chr;
   } token_type;

   function automatic token_type classify(input logic [7:0] c);
      token_type t;
      t.chr    = c;
      t.is_s   = (c == CHAR_S);
      t.hex_ok = 1'b0;
      t.nib    = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         t.hex_ok = 1'b1;
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         t.hex_ok = 1'b1;
         t.nib    = c[3:0] + 4'd9;
      end
      return t;
   endfunction

endpackage

### rtl/srec_ifs.sv
// Valid/ready channel interfaces for the S-record loader: characters in, results out.
// Depends on nothing.
interface srec_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

interface srec_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] write_address;
   logic [7:0]  write_byte;

   modport source (output valid, output kind, output write_address, output write_byte,
                   input ready);
   modport sink (input valid, input kind, input write_address, input write_byte,
                 output ready);
endinterface

### rtl/srec_front.sv
// Front end: accepts characters, classifies them and holds them in a short queue.
// Depends on srec_pkg and srec_char_if.
module srec_front #(
   parameter int Depth = srec_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   srec_char_if.sink           req_chan,
   output logic                q_valid,
   output srec_pkg::token_type q_tok,
   input  logic                q_pop
);
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   srec_pkg::token_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push, pop;

   assign req_chan.ready = (count_ff != FullCnt);
   assign push = req_chan.valid && req_chan.ready;
   assign q_valid = (count_ff != '0);
   assign pop = q_pop && q_valid;
   assign q_tok = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= srec_pkg::classify(req_chan.char_in);
      end
   end

endmodule

### rtl/srec_back.sv
// Back end: record parser state machine and the result output register.
// Depends on srec_pkg and srec_rsp_if.
module srec_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  srec_pkg::token_type q_tok,
   output logic                q_pop,
   srec_rsp_if.source          rsp_chan
);
   srec_pkg::phase_type phase_ff, phase_in;
   logic        halted_ff, halted_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  left_ff, left_in;
   logic [3:0]  digit_ff, digit_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  index_ff, index_in;

   logic                rsp_valid_ff, rsp_valid_in;
   srec_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [31:0]         rsp_addr_ff, rsp_addr_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;

   logic        live, emit;
   logic [3:0]  dig_inc;
   logic        adr_last, byte_last;
   logic [7:0]  acc_new, left_dec;
   logic        is_t0, is_t3, is_t7;

   // Take the next item only when the output register is free or draining.
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign live  = q_pop && !halted_ff;

   assign dig_inc   = digit_ff + 4'd1;
   assign adr_last  = dig_inc == ((phase_ff == srec_pkg::PH_S0ADR) ?
                                  srec_pkg::S0_ADDR_DIGITS : srec_pkg::S3_ADDR_DIGITS);
   assign byte_last = (digit_ff != 4'd0);
   assign acc_new   = {acc_ff[3:0], q_tok.nib};
   assign left_dec  = (left_ff == 8'd0) ? 8'd0 : left_ff - 8'd1;
   assign is_t0     = (type_ff == srec_pkg::CHAR_0);
   assign is_t3     = (type_ff == srec_pkg::CHAR_3);
   assign is_t7     = (type_ff == srec_pkg::CHAR_7);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (live) begin
         case (phase_ff)
            srec_pkg::PH_HUNT: begin
               phase_in = q_tok.is_s ? srec_pkg::PH_TYPE : srec_pkg::PH_HUNT;
            end
            srec_pkg::PH_TYPE: begin
               phase_in = srec_pkg::PH_COUNT;
            end
            srec_pkg::PH_COUNT: begin
               if (!q_tok.hex_ok) begin
                  phase_in = srec_pkg::PH_HUNT;
               end else if (byte_last) begin
                  if (is_t0) phase_in = srec_pkg::PH_S0ADR;
                  else if (is_t3) phase_in = srec_pkg::PH_S3ADR;
                  else phase_in = srec_pkg::PH_HUNT;
               end
            end
            srec_pkg::PH_S0ADR, srec_pkg::PH_S3ADR: begin
               if (!q_tok.hex_ok) begin
                  phase_in = srec_pkg::PH_HUNT;
               end else if (adr_last) begin
                  if (left_ff == 8'd0) phase_in = srec_pkg::PH_HUNT;
                  else if (phase_ff == srec_pkg::PH_S0ADR) phase_in = srec_pkg::PH_S0DAT;
                  else phase_in = srec_pkg::PH_S3DAT;
               end
            end
            srec_pkg::PH_S0DAT, srec_pkg::PH_S3DAT: begin
               if (!q_tok.hex_ok || (byte_last && left_dec == 8'd0)) begin
                  phase_in = srec_pkg::PH_HUNT;
               end
            end
            default: phase_in = srec_pkg::PH_HUNT;
         endcase
      end
   end

   // Field registers, stop flag and result.
   always_comb begin
      halted_in   = halted_ff;
      type_in     = type_ff;
      left_in     = left_ff;
      digit_in    = digit_ff;
      addr_in     = addr_ff;
      acc_in      = acc_ff;
      index_in    = index_ff;
      emit        = 1'b0;
      rsp_kind_in = srec_pkg::KIND_WRITE;
      rsp_addr_in = 32'd0;
      rsp_byte_in = 8'd0;
      if (live) begin
         case (phase_ff)
            srec_pkg::PH_HUNT: begin
            end
            srec_pkg::PH_TYPE: begin
               type_in  = q_tok.chr;
               digit_in = 4'd0;
               acc_in   = 8'd0;
            end
            default: begin
               if (!q_tok.hex_ok) begin
                  halted_in   = 1'b1;
                  emit        = 1'b1;
                  rsp_kind_in = srec_pkg::KIND_HEX;
               end else if (phase_ff == srec_pkg::PH_S0ADR ||
                            phase_ff == srec_pkg::PH_S3ADR) begin
                  addr_in  = {addr_ff[27:0], q_tok.nib};
                  digit_in = adr_last ? 4'd0 : dig_inc;
                  if (adr_last) acc_in = 8'd0;
               end else if (!byte_last) begin
                  acc_in   = acc_new;
                  digit_in = dig_inc;
               end else if (phase_ff == srec_pkg::PH_COUNT) begin
                  digit_in = 4'd0;
                  acc_in   = 8'd0;
                  addr_in  = 32'd0;
                  index_in = 8'd0;
                  if (is_t0) begin
                     left_in = (acc_new >= srec_pkg::S0_OVERHEAD) ?
                               acc_new - srec_pkg::S0_OVERHEAD : 8'd0;
                  end else if (is_t3) begin
                     left_in = (acc_new >= srec_pkg::S3_OVERHEAD) ?
                               acc_new - srec_pkg::S3_OVERHEAD : 8'd0;
                  end else begin
                     left_in     = acc_new;
                     halted_in   = 1'b1;
                     emit        = 1'b1;
                     rsp_kind_in = is_t7 ? srec_pkg::KIND_DONE : srec_pkg::KIND_TYPE;
                  end
               end else begin
                  digit_in = 4'd0;
                  acc_in   = 8'd0;
                  index_in = index_ff + 8'd1;
                  left_in  = left_dec;
                  if (phase_ff == srec_pkg::PH_S3DAT) begin
                     emit        = 1'b1;
                     rsp_kind_in = srec_pkg::KIND_WRITE;
                     rsp_addr_in = addr_ff + {24'd0, index_ff};
                     rsp_byte_in = acc_new;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= srec_pkg::PH_HUNT;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         type_ff      <= 8'd0;
         left_ff      <= 8'd0;
         digit_ff     <= 4'd0;
         addr_ff      <= 32'd0;
         acc_ff       <= 8'd0;
         index_ff     <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         type_ff      <= type_in;
         left_ff      <= left_in;
         digit_ff     <= digit_in;
         addr_ff      <= addr_in;
         acc_ff       <= acc_in;
         index_ff     <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.write_address = rsp_addr_ff;
   assign rsp_chan.write_byte    = rsp_byte_ff;

endmodule

### rtl/srec_record_loader.sv
// S-record loader top level: the front queue feeding the record parser.
// Depends on srec_pkg, srec_ifs, srec_front and srec_back.
//
// Takes Motorola S-record text one character per cycle on req_chan and gives
// memory writes (kind 0), an end-of-load mark on S7 (kind 1) or a stop on an
// unknown record type (kind 2) or a bad hex digit (kind 3) on rsp_chan. After
// any stop the block drains and drops input until reset. Sustained rate is one
// character per cycle, set by the parser state update in the back end; a result
// is registered: its last character is written into the queue, the parser reads
// it at the queue head and the result is loaded into the output register. While
// a result waits on rsp_chan the parser holds, and input is taken only until
// the queue of QueueDepth characters is full.
module srec_record_loader #(
   parameter int QueueDepth = srec_pkg::QUEUE_DEPTH
) (
   input logic         clock,
   input logic         reset,
   srec_char_if.sink   req_chan,
   srec_rsp_if.source  rsp_chan
);
   logic                q_valid;
   logic                q_pop;
   srec_pkg::token_type q_tok;

   srec_front #(
      .Depth(QueueDepth)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .q_valid (q_valid),
      .q_tok   (q_tok),
      .q_pop   (q_pop)
   );

   srec_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_tok   (q_tok),
      .q_pop   (q_pop),
      .rsp_chan(rsp_chan)
   );

endmodule

### rtl/srec_checker.sv
// Port-level checks of the S-record loader, attached to the top level by bind.
// Depends on srec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_write_address,
   input logic [7:0]  rsp_write_byte
);
   logic        stop_taken;
   logic        stop_shown;
   logic        rsp_stall;
   logic        write_zero;
   logic [41:0] rsp_payload;

   assign stop_shown  = rsp_valid && (rsp_kind != srec_pkg::KIND_WRITE);
   assign stop_taken  = stop_shown && rsp_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign write_zero  = (rsp_write_address == 32'd0) && (rsp_write_byte == 8'd0);
   assign rsp_payload = {rsp_kind, rsp_write_address, rsp_write_byte};

   `SREC_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "result dropped")
   `SREC_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_payload), "result changed")
   `SREC_ASSERT(a_stop_final, clock, reset, stop_taken |=> !rsp_valid, "result after a stop")
   `SREC_ASSERT(a_stop_zero, clock, reset, stop_shown |-> write_zero, "stop with write fields")
   `SREC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind srec_record_loader srec_checker u_srec_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_write_address(rsp_chan.write_address),
   .rsp_write_byte   (rsp_chan.write_byte)
);
